// File: hdl/sle_pkg.sv
// Shared command, status and sequencer types for the sequential list engine.
`default_nettype none

package sle_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SWEEP  = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  // Field widths of the stream payloads
  localparam int POS_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int IN_TD_W = 16;
  localparam int OUT_TD_W = 32;

endpackage

`default_nettype wire

// File: hdl/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/sequential_list_engine.sv
// Top level of the sequential list engine: command sequencer around one RAM.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tuser: cmd; tdata: position, value_in
//  out_    | out | out_tvalid / out_tready| tdata: status, value_out, found_position,
//          |     |                        |        list_count, is_empty
//
// Each item walks R entries through the RAM read port, one per cycle:
// insert count-position+1, delete count-position+1, read 1, search count,
// otherwise 0. At most DEPTH entries are walked.
// Reset (synchronous, rst_n low) empties the list; RAM contents are not cleared.
// in_tready is high only while the sequencer is idle; a finished result sits in
// the output register so the next item is taken while it waits.
// A stalled output holds the sequencer in its last state until the slot frees.
`default_nettype none

module sequential_list_engine #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [2:0]                    in_tuser,   // [2:0] cmd
  input  wire logic [sle_pkg::IN_TD_W-1:0]   in_tdata,   // [6:0] position, [14:7] value_in
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [sle_pkg::OUT_TD_W-1:0]  out_tdata   // [1:0] status, [9:2] value_out,
                                                         // [16:10] found_position,
                                                         // [23:17] list_count, [24] is_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;
  localparam int EW = ELEM_WIDTH;

  // Sequencer and command registers
  sle_pkg::state_t  state_r, state_nxt;
  sle_pkg::cmd_t    cmd_r, cmd_nxt;
  sle_pkg::status_t status_r, status_nxt;
  logic [EW-1:0]    val_r, val_nxt;
  logic [AW-1:0]    pos_m1_r, pos_m1_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Sweep control
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]    rd_end_r, rd_end_nxt;
  logic             rd_down_r, rd_down_nxt;
  logic             rd_go_r, rd_go_nxt;
  logic             live_r, live_nxt;
  logic [AW-1:0]    tag_r, tag_nxt;

  // Gathered results
  logic [EW-1:0]    vout_r, vout_nxt;
  logic [PW-1:0]    found_r, found_nxt;
  logic             hit_r, hit_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [sle_pkg::OUT_TD_W-1:0]  out_data_r, out_data_nxt;

  // RAM port signals
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [EW-1:0]  mem_wdata;
  logic [EW-1:0]  mem_rdata;

  // Input field decode
  logic [PW-1:0]  pos_w, cnt_w, pos_m1_w, cnt_m1_w, cnt_p1_w, tag_p1_w;
  logic [EW-1:0]  val_c;
  logic [sle_pkg::BYTE_W-1:0] vout_byte;
  logic [PW-1:0]  cnt_new_w;
  logic           in_acc;

  assign in_acc   = in_tvalid && in_tready;
  assign pos_w    = PW'(in_tdata[sle_pkg::POS_W-1:0]);
  assign cnt_w    = PW'(count_r);
  assign pos_m1_w = pos_w - PW'(1);
  assign cnt_m1_w = cnt_w - PW'(1);
  assign cnt_p1_w = cnt_w + PW'(1);
  assign tag_p1_w = PW'(tag_r) + PW'(1);

  // Fit the 8-bit value field to the element width, and an element back to a byte
  for (genvar gi = 0; gi < EW; gi++) begin : g_val_in
    if (gi < sle_pkg::BYTE_W) begin : g_bit
      assign val_c[gi] = in_tdata[sle_pkg::POS_W + gi];
    end else begin : g_zero
      assign val_c[gi] = 1'b0;
    end
  end

  for (genvar gb = 0; gb < sle_pkg::BYTE_W; gb++) begin : g_val_out
    if (gb < EW) begin : g_bit
      assign vout_byte[gb] = vout_r[gb];
    end else begin : g_zero
      assign vout_byte[gb] = 1'b0;
    end
  end

  sle_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx_r),
    .rdata (mem_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sle_pkg::S_IDLE;
      count_r     <= '0;
      rd_go_r     <= 1'b0;
      live_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_go_r     <= rd_go_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    val_r      <= val_nxt;
    pos_m1_r   <= pos_m1_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_end_r   <= rd_end_nxt;
    rd_down_r  <= rd_down_nxt;
    tag_r      <= tag_nxt;
    vout_r     <= vout_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next count for the command just finished
  always_comb begin
    cnt_new_w = cnt_w;
    if (status_r == sle_pkg::ST_OK) begin
      case (cmd_r)
        sle_pkg::CMD_INSERT: cnt_new_w = cnt_p1_w;
        sle_pkg::CMD_DELETE: cnt_new_w = cnt_m1_w;
        sle_pkg::CMD_CLEAR:  cnt_new_w = '0;
        default:             cnt_new_w = cnt_w;
      endcase
    end
  end

  // Sequencer: decode on accept, sweep the RAM, then post the result
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    val_nxt       = val_r;
    pos_m1_nxt    = pos_m1_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_end_nxt    = rd_end_r;
    rd_down_nxt   = rd_down_r;
    rd_go_nxt     = rd_go_r;
    live_nxt      = 1'b0;
    tag_nxt       = rd_idx_r;
    vout_nxt      = vout_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = tag_r;
    mem_wdata     = mem_rdata;
    in_tready     = (state_r == sle_pkg::S_IDLE);

    case (state_r)
      sle_pkg::S_IDLE: begin
        rd_go_nxt = 1'b0;
        if (in_acc) begin
          cmd_nxt    = sle_pkg::cmd_t'(in_tuser);
          val_nxt    = val_c;
          pos_m1_nxt = pos_m1_w[AW-1:0];
          status_nxt = sle_pkg::ST_OK;
          vout_nxt   = '0;
          found_nxt  = '0;
          hit_nxt    = 1'b0;
          state_nxt  = sle_pkg::S_SWEEP;
          case (sle_pkg::cmd_t'(in_tuser))
            sle_pkg::CMD_INSERT: begin
              // Walk from the top entry down to the insert slot
              rd_idx_nxt  = cnt_m1_w[AW-1:0];
              rd_end_nxt  = pos_m1_w[AW-1:0];
              rd_down_nxt = 1'b1;
              if (pos_w == '0 || pos_w > cnt_p1_w) begin
                status_nxt = sle_pkg::ST_RANGE;
              end else if (cnt_w == PW'(DEPTH)) begin
                status_nxt = sle_pkg::ST_FULL;
              end else begin
                rd_go_nxt = (cnt_w >= pos_w);
              end
            end
            sle_pkg::CMD_DELETE, sle_pkg::CMD_READ: begin
              // Delete walks from the slot up to the top; read takes one entry
              rd_idx_nxt  = pos_m1_w[AW-1:0];
              rd_down_nxt = 1'b0;
              if (sle_pkg::cmd_t'(in_tuser) == sle_pkg::CMD_DELETE) begin
                rd_end_nxt = cnt_m1_w[AW-1:0];
              end else begin
                rd_end_nxt = pos_m1_w[AW-1:0];
              end
              if (pos_w == '0 || pos_w > cnt_w) begin
                status_nxt = sle_pkg::ST_RANGE;
              end else begin
                rd_go_nxt = 1'b1;
              end
            end
            sle_pkg::CMD_SEARCH: begin
              rd_idx_nxt  = '0;
              rd_end_nxt  = cnt_m1_w[AW-1:0];
              rd_down_nxt = 1'b0;
              rd_go_nxt   = (cnt_w != '0);
            end
            default: begin
              rd_go_nxt = 1'b0;
            end
          endcase
        end
      end

      sle_pkg::S_SWEEP: begin
        // Issue the next read
        if (rd_go_r) begin
          live_nxt = 1'b1;
          if (rd_idx_r == rd_end_r) begin
            rd_go_nxt = 1'b0;
          end else if (rd_down_r) begin
            rd_idx_nxt = rd_idx_r - AW'(1);
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
        // Consume the data of the read issued last cycle
        if (live_r) begin
          case (cmd_r)
            sle_pkg::CMD_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = tag_p1_w[AW-1:0];
            end
            sle_pkg::CMD_DELETE: begin
              if (tag_r == pos_m1_r) begin
                vout_nxt = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tag_r - AW'(1);
              end
            end
            sle_pkg::CMD_READ: begin
              vout_nxt = mem_rdata;
            end
            sle_pkg::CMD_SEARCH: begin
              if (!hit_r && mem_rdata == val_r) begin
                hit_nxt   = 1'b1;
                found_nxt = tag_p1_w;
              end
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end
        // Leave once no read is pending; the last data is consumed this cycle
        if (!rd_go_r) begin
          state_nxt = sle_pkg::S_FINISH;
        end
      end

      sle_pkg::S_FINISH: begin
        // Drop the new element into its slot, then post the result
        if (cmd_r == sle_pkg::CMD_INSERT && status_r == sle_pkg::ST_OK) begin
          mem_we    = 1'b1;
          mem_waddr = pos_m1_r;
          mem_wdata = val_r;
        end
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          count_nxt     = cnt_new_w[CW-1:0];
          out_data_nxt  = {7'd0,
                           (cnt_new_w == '0),
                           cnt_new_w[sle_pkg::POS_W-1:0],
                           found_r[sle_pkg::POS_W-1:0],
                           vout_byte,
                           status_r};
          state_nxt     = sle_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sle_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The list never grows past the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(count_r) <= PW'(DEPTH))
    else $error("list count exceeds store depth");

  // An accepted item closes the input until its result is posted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input reopened right after accept");

  // The count only moves when a result is posted
  a_count_moves_on_post: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sle_pkg::S_FINISH) |=> $stable(count_r))
    else $error("count changed outside result posting");

  // The store is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sle_pkg::S_IDLE) |-> !mem_we)
    else $error("store written while idle");

endmodule

`default_nettype wire
